// ----- design/spfm_pkg.sv -----
// Shared constants for the speed-profile frame mapper.
// Register map indexes and profile codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spfm_pkg;

  // register map, index = byte address / 4
  localparam logic [2:0] REG_CLIP_DURATION  = 3'd0;
  localparam logic [2:0] REG_SOURCE_IN      = 3'd1;
  localparam logic [2:0] REG_SOURCE_OUT     = 3'd2;
  localparam logic [2:0] REG_PLAYBACK_SPEED = 3'd3;
  localparam logic [2:0] REG_REVERSE        = 3'd4;
  localparam logic [2:0] REG_PROFILE        = 3'd5;
  localparam logic [2:0] REG_CURVE_STRENGTH = 3'd6;

  // speed profile codes; anything above hyperlapse is a constant curve
  localparam logic [2:0] PROF_LINEAR      = 3'd0;
  localparam logic [2:0] PROF_EASE_IN     = 3'd1;
  localparam logic [2:0] PROF_EASE_OUT    = 3'd2;
  localparam logic [2:0] PROF_EASE_IN_OUT = 3'd3;
  localparam logic [2:0] PROF_HYPERLAPSE  = 3'd4;

endpackage

`default_nettype wire

// ----- design/spfm_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Carries a side payload alongside; standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module spfm_div #(
  parameter int NW = 33,
  parameter int DW = 19,
  parameter int QW = 19,
  parameter int PW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  input  logic [PW-1:0] in_payload,
  output logic          out_valid,
  output logic [QW-1:0] quotient,
  output logic [PW-1:0] out_payload
);

  // remainder must hold both the dividend and the most shifted divisor
  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic          vld [1:QW];
  logic [RW-1:0] rem [1:QW];
  logic [DW-1:0] dvs [1:QW];
  logic [QW-1:0] quo [1:QW];
  logic [PW-1:0] pay [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int BIT = QW - 1 - s;
    logic          vi;
    logic [RW-1:0] ri;
    logic [DW-1:0] di;
    logic [QW-1:0] qi;
    logic [PW-1:0] pi;
    logic [RW-1:0] trial;
    logic          ge;
    logic [QW-1:0] q_next;

    if (s == 0) begin : g_first
      assign vi = in_valid;
      assign ri = RW'(dividend);
      assign di = divisor;
      assign qi = '0;
      assign pi = in_payload;
    end else begin : g_next
      assign vi = vld[s];
      assign ri = rem[s];
      assign di = dvs[s];
      assign qi = quo[s];
      assign pi = pay[s];
    end

    // trial subtract of the divisor aligned to this quotient bit
    assign trial = RW'(di) << BIT;
    assign ge    = (ri >= trial);

    always_comb begin
      q_next      = qi;
      q_next[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1] <= ge ? (ri - trial) : ri;
        dvs[s+1] <= di;
        quo[s+1] <= q_next;
        pay[s+1] <= pi;
      end
    end
  end

  assign out_valid   = vld[QW];
  assign quotient    = quo[QW];
  assign out_payload = pay[QW];

endmodule

`default_nettype wire

// ----- design/speed_profile_frame_mapper.sv -----
// Speed-profile frame mapper: an accepted beat reaches its result beat through registered
// stages and two bit-per-stage dividers (strength reciprocal, then the segment interpolation);
// XW = max(24, 8 + SPEED_FRAC_BITS). Throughput one beat per cycle unless the receiver stalls;
// an output register plus a skid register hold beats, and input stalls while the skid is full.
// Synchronous reset clears all valid bits and loads register defaults; no clearing pass.
// Uses spfm_pkg and spfm_div.
`timescale 1ns / 1ps
`default_nettype none

module speed_profile_frame_mapper #(
  parameter int TIME_BITS       = 32,
  parameter int SPEED_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               local_valid,
  output logic               local_stall,
  input  logic signed [31:0] local_position,
  output logic               source_valid,
  input  logic               source_stall,
  output logic [31:0]        source_position
);

  localparam int F    = SPEED_FRAC_BITS;
  localparam int SW   = 8 + F;
  localparam int XW   = (SW > 24) ? SW : 24;
  localparam int TB   = TIME_BITS;
  localparam int MW   = (TB > 32) ? TB : 32;
  localparam int WIDE = 32 + XW + F + 4;
  localparam int PKW  = 2 * F + 4;

  localparam longint unsigned ONE_L     = 64'd1 << F;
  localparam longint unsigned SPD_MIN_L = (ONE_L + 64'd5) / 64'd10;
  localparam longint unsigned STR_MAX_L = ONE_L * 64'd4;
  localparam longint unsigned QC_9_50   = (ONE_L * 64'd9 + 64'd25) / 64'd50;
  localparam longint unsigned QC_9_10   = (ONE_L * 64'd9 + 64'd5) / 64'd10;
  localparam longint unsigned QC_11_20  = (ONE_L * 64'd11 + 64'd10) / 64'd20;
  localparam longint unsigned QC_17_20  = (ONE_L * 64'd17 + 64'd10) / 64'd20;
  localparam longint unsigned QC_23_20  = (ONE_L * 64'd23 + 64'd10) / 64'd20;
  localparam longint unsigned QC_29_20  = (ONE_L * 64'd29 + 64'd10) / 64'd20;
  localparam longint unsigned QC_6_5    = (ONE_L * 64'd6 + 64'd2) / 64'd5;
  localparam longint unsigned QC_9_5    = (ONE_L * 64'd9 + 64'd2) / 64'd5;
  localparam longint unsigned SPD_MAX_L = (64'd1 << SW) - 64'd1;
  localparam longint unsigned TIME_MAX_L = (64'd1 << TB) - 64'd1;
  localparam longint unsigned SLOW_NUM  = QC_11_20 << F;

  localparam int NW1 = 2 * F + 1;
  localparam int DW1 = F + 3;
  localparam int QW1 = F + 3;
  localparam int NW2 = 32 + XW;
  localparam int DW2 = 33;
  localparam int QW2 = XW - 1;
  localparam int PW2 = TB + XW + 1 + 32 + 32;

  localparam logic [XW-1:0] SPD_MIN = XW'(SPD_MIN_L);

  // saturate to the speed range, then to the timeline range
  function automatic logic [XW-1:0] sat_spd(input logic [WIDE-1:0] v);
    return (v > WIDE'(SPD_MAX_L)) ? XW'(SPD_MAX_L) : v[XW-1:0];
  endfunction

  function automatic logic [TB-1:0] sat_time(input logic [WIDE-1:0] v);
    return (v > WIDE'(TIME_MAX_L)) ? TB'(TIME_MAX_L) : v[TB-1:0];
  endfunction

  function automatic logic [XW-1:0] flr(input logic [XW-1:0] x);
    return (x < SPD_MIN) ? SPD_MIN : x;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [31:0] clip_duration;
  logic [31:0] source_in;
  logic [31:0] source_out;
  logic [23:0] playback_speed;
  logic        reverse;
  logic [2:0]  profile;
  logic [23:0] curve_strength;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_duration  <= 32'd1;
      source_in      <= 32'd0;
      source_out     <= 32'd1;
      playback_speed <= 24'h010000;
      reverse        <= 1'b0;
      profile        <= spfm_pkg::PROF_LINEAR;
      curve_strength <= 24'h010000;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        spfm_pkg::REG_CLIP_DURATION:  clip_duration  <= pwdata;
        spfm_pkg::REG_SOURCE_IN:      source_in      <= pwdata;
        spfm_pkg::REG_SOURCE_OUT:     source_out     <= pwdata;
        spfm_pkg::REG_PLAYBACK_SPEED: playback_speed <= pwdata[23:0];
        spfm_pkg::REG_REVERSE:        reverse        <= pwdata[0];
        spfm_pkg::REG_PROFILE:        profile        <= pwdata[2:0];
        spfm_pkg::REG_CURVE_STRENGTH: curve_strength <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      spfm_pkg::REG_CLIP_DURATION:  prdata = clip_duration;
      spfm_pkg::REG_SOURCE_IN:      prdata = source_in;
      spfm_pkg::REG_SOURCE_OUT:     prdata = source_out;
      spfm_pkg::REG_PLAYBACK_SPEED: prdata = {8'd0, playback_speed};
      spfm_pkg::REG_REVERSE:        prdata = {31'd0, reverse};
      spfm_pkg::REG_PROFILE:        prdata = {29'd0, profile};
      spfm_pkg::REG_CURVE_STRENGTH: prdata = {8'd0, curve_strength};
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // values derived from configuration only (keep it stable while beats are in flight; not enforced)
  logic [31:0]    dur, end_u, mid_u, room;
  logic           empty_span, lin_path, three;
  logic [63:0]    pb_w, cs_w, base_w, strc_w;
  logic [XW-1:0]  base;
  logic [F+2:0]   strc;

  assign dur        = (clip_duration == 32'd0) ? 32'd1 : clip_duration;
  assign end_u      = dur - 32'd1;
  assign mid_u      = end_u >> 1;
  assign room       = source_out - 32'd1 - source_in;
  assign empty_span = (source_out <= source_in);
  assign lin_path   = (profile == spfm_pkg::PROF_LINEAR) || (dur == 32'd1);
  assign three      = (profile == spfm_pkg::PROF_EASE_IN_OUT) ||
                      (profile == spfm_pkg::PROF_HYPERLAPSE);
  assign pb_w       = 64'(playback_speed);
  assign cs_w       = 64'(curve_strength);
  assign base_w     = (pb_w < SPD_MIN_L) ? SPD_MIN_L : pb_w;
  assign strc_w     = (cs_w < SPD_MIN_L) ? SPD_MIN_L :
                      (cs_w > STR_MAX_L) ? STR_MAX_L : cs_w;
  assign base       = XW'(base_w);
  assign strc       = strc_w[F+2:0];

  // ---------------------------------------------------------------------------
  // pipeline advance: frozen only while the skid register is occupied
  logic adv, skid_full;
  assign adv         = !skid_full;
  assign local_stall = skid_full;

  // stage 1: input beat
  logic        v1;
  logic [31:0] raw1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= local_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) raw1 <= local_position;
  end

  // stage 2: clamp position into the clip
  logic        v2;
  logic [31:0] loc2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (adv) loc2 <= raw1[31] ? 32'd0 : ((raw1 > end_u) ? end_u : raw1);
  end

  // strength reciprocal: 0.55 / strength
  logic           v3;
  logic [QW1-1:0] q3;
  logic [31:0]    loc3;

  spfm_div #(.NW(NW1), .DW(DW1), .QW(QW1), .PW(32)) u_div_slow (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (v2),
    .dividend   (NW1'(SLOW_NUM)),
    .divisor    (strc),
    .in_payload (loc2),
    .out_valid  (v3),
    .quotient   (q3),
    .out_payload(loc3)
  );

  // stage 4: factor products
  logic [63:0]          q3_w, qc_w;
  logic [F-1:0]         qc;
  logic [F+2:0]         dstr;
  logic [F:0]           kk;
  logic                 v4, sge4;
  logic [XW+F-1:0]      pslow4;
  logic [PKW-1:0]       pk4, ph2_4, ph3_4;
  logic [XW+F:0]        ph1_4;
  logic [32+XW:0]       plin4;
  logic [31:0]          loc4;

  assign q3_w = 64'(q3);
  assign qc_w = (q3_w < QC_9_50) ? QC_9_50 : (q3_w > QC_9_10) ? QC_9_10 : q3_w;
  assign qc   = qc_w[F-1:0];
  assign dstr = (64'(strc) >= ONE_L) ? (strc - (F+3)'(ONE_L)) : ((F+3)'(ONE_L) - strc);
  assign kk   = (profile == spfm_pkg::PROF_EASE_IN_OUT) ? (F+1)'(QC_23_20) : (F+1)'(QC_17_20);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sge4   <= (64'(strc) >= ONE_L);
      pslow4 <= (XW+F)'(base) * (XW+F)'(qc);
      pk4    <= PKW'(dstr) * PKW'(kk);
      ph1_4  <= (XW+F+1)'(base) * (XW+F+1)'(QC_29_20);
      ph2_4  <= PKW'(strc) * PKW'(QC_6_5);
      ph3_4  <= PKW'(strc) * PKW'(QC_9_5);
      plin4  <= (33+XW)'(loc3) * (33+XW)'(base) + (33+XW)'(ONE_L >> 1);
      loc4   <= loc3;
    end
  end

  // stage 5: slow speed, ramp factor, hyperlapse speeds, linear offset
  logic [F+3:0]    m5;
  logic [F+2:0]    f5_next;
  logic            rmin5_next;
  logic [XW-1:0]   bmax1, h1, h2, e1, e2;
  logic [32+XW:0]  linoff;
  logic            v5, rmin5;
  logic [F+2:0]    f5;
  logic [XW-1:0]   slow5, hm5, hend5, hstart5;
  logic [31:0]     lin5, loc5;

  assign m5 = (F+4)'(pk4 >> F);

  always_comb begin
    rmin5_next = 1'b0;
    f5_next    = '0;
    if (sge4) begin
      f5_next = (F+3)'(ONE_L) + (F+3)'(m5);
    end else if (64'(m5) >= ONE_L) begin
      rmin5_next = 1'b1;
    end else begin
      f5_next = (F+3)'(ONE_L) - (F+3)'(m5);
    end
  end

  assign bmax1  = (64'(base) > ONE_L) ? base : XW'(ONE_L);
  assign h1     = sat_spd(WIDE'(ph1_4 >> F));
  assign h2     = sat_spd(WIDE'(ph2_4 >> F));
  assign e1     = sat_spd(WIDE'({base, 1'b0}));
  assign e2     = sat_spd(WIDE'(ph3_4 >> F));
  assign linoff = plin4 >> F;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      slow5   <= flr(sat_spd(WIDE'(pslow4 >> F)));
      f5      <= f5_next;
      rmin5   <= rmin5_next;
      hm5     <= flr((h1 > h2) ? h1 : h2);
      hend5   <= flr((e1 > e2) ? e1 : e2);
      hstart5 <= flr(sat_spd(WIDE'(bmax1)));
      lin5    <= (linoff > (33+XW)'(room)) ? room : linoff[31:0];
      loc5    <= loc4;
    end
  end

  // stage 6: ramp product
  logic              v6, rmin6;
  logic [XW+F+2:0]   pr6;
  logic [XW-1:0]     slow6, hm6, hend6, hstart6;
  logic [31:0]       lin6, loc6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pr6     <= (XW+F+3)'(base) * (XW+F+3)'(f5);
      rmin6   <= rmin5;
      slow6   <= slow5;
      hm6     <= hm5;
      hend6   <= hend5;
      hstart6 <= hstart5;
      lin6    <= lin5;
      loc6    <= loc5;
    end
  end

  // stage 7: curve points; a two-point curve ends its first segment at the end
  logic [XW-1:0] ramp, st, md, en;
  logic [XW-1:0] a_next, b_next, c_next;
  logic [31:0]   t1_next;
  logic          v7;
  logic [XW-1:0] a7, b7, c7;
  logic [31:0]   t17, lin7, loc7;

  assign ramp = rmin6 ? SPD_MIN : flr(sat_spd(WIDE'(pr6 >> F)));

  always_comb begin
    case (profile)
      spfm_pkg::PROF_EASE_IN: begin
        st = slow6; md = base; en = ramp;
      end
      spfm_pkg::PROF_EASE_OUT: begin
        st = ramp; md = base; en = slow6;
      end
      spfm_pkg::PROF_EASE_IN_OUT: begin
        st = slow6; md = ramp; en = slow6;
      end
      spfm_pkg::PROF_HYPERLAPSE: begin
        st = hstart6; md = hm6; en = hend6;
      end
      default: begin
        st = base; md = base; en = base;
      end
    endcase
  end

  always_comb begin
    c_next = en;
    if (three && mid_u == 32'd0) begin
      // middle point at zero replaces the start point
      a_next = md; b_next = en; t1_next = end_u;
    end else if (three) begin
      a_next = st; b_next = md; t1_next = mid_u;
    end else begin
      a_next = st; b_next = en; t1_next = end_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (adv) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a7   <= a_next;
      b7   <= b_next;
      c7   <= c_next;
      t17  <= t1_next;
      lin7 <= lin6;
      loc7 <= loc6;
    end
  end

  // stage 8: pick the segment holding the position
  logic          seg2_c, up_c;
  logic [XW-1:0] prev_c, nxt_c;
  logic [XW:0]   sum_ab;
  logic          v8, seg28, up8;
  logic [XW-1:0] prev8, diff8, avg8;
  logic [31:0]   dt8, span8, t18, lin8;

  assign seg2_c = (loc7 > t17);
  assign prev_c = seg2_c ? b7 : a7;
  assign nxt_c  = seg2_c ? c7 : b7;
  assign up_c   = (nxt_c >= prev_c);
  assign sum_ab = (XW+1)'(a7) + (XW+1)'(b7);

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (adv) v8 <= v7;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      seg28 <= seg2_c;
      up8   <= up_c;
      prev8 <= prev_c;
      diff8 <= up_c ? (nxt_c - prev_c) : (prev_c - nxt_c);
      avg8  <= sum_ab[XW:1];
      dt8   <= seg2_c ? (loc7 - t17) : loc7;
      span8 <= seg2_c ? (end_u - t17) : t17;
      t18   <= t17;
      lin8  <= lin7;
    end
  end

  // stage 9: slope product and first-segment area
  logic          v9, seg29, up9;
  logic [NW2-1:0] pd9, pacc9;
  logic [XW-1:0] prev9;
  logic [31:0]   dt9, span9, lin9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (adv) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      pd9   <= NW2'(diff8) * NW2'(dt8);
      pacc9 <= NW2'(t18) * NW2'(avg8);
      seg29 <= seg28;
      up9   <= up8;
      prev9 <= prev8;
      dt9   <= dt8;
      span9 <= span8;
      lin9  <= lin8;
    end
  end

  // stage 10: accumulated area before the segment
  logic           v10, up10;
  logic [NW2-1:0] pd10;
  logic [TB-1:0]  acc10;
  logic [XW-1:0]  prev10;
  logic [31:0]    dt10, span10, lin10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (adv) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      acc10  <= seg29 ? sat_time(WIDE'(pacc9 >> F)) : '0;
      pd10   <= pd9;
      up10   <= up9;
      prev10 <= prev9;
      dt10   <= dt9;
      span10 <= span9;
      lin10  <= lin9;
    end
  end

  // interpolation step: slope * dt / (2 * span)
  logic           v11, up11;
  logic [QW2-1:0] q11;
  logic [PW2-1:0] pay11;
  logic [TB-1:0]  acc11;
  logic [XW-1:0]  prev11;
  logic [31:0]    dt11, lin11;

  spfm_div #(.NW(NW2), .DW(DW2), .QW(QW2), .PW(PW2)) u_div_seg (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (v10),
    .dividend   (pd10),
    .divisor    ({span10, 1'b0}),
    .in_payload ({acc10, prev10, up10, dt10, lin10}),
    .out_valid  (v11),
    .quotient   (q11),
    .out_payload(pay11)
  );

  assign {acc11, prev11, up11, dt11, lin11} = pay11;

  // stage 12: speed at the position, times dt
  logic [XW-1:0]  cs;
  logic           v12;
  logic [NW2-1:0] prod12;
  logic [TB-1:0]  acc12;
  logic [31:0]    lin12;

  assign cs = up11 ? (prev11 + XW'(q11)) : (prev11 - XW'(q11));

  always_ff @(posedge clk) begin
    if (rst) v12 <= 1'b0;
    else if (adv) v12 <= v11;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      prod12 <= NW2'(dt11) * NW2'(cs);
      acc12  <= acc11;
      lin12  <= lin11;
    end
  end

  // stage 13: saturating total
  logic [TB-1:0] term;
  logic [TB:0]   tot;
  logic          v13;
  logic [TB-1:0] off13;
  logic [31:0]   lin13;

  assign term = sat_time(WIDE'(prod12 >> F));
  assign tot  = (TB+1)'(acc12) + (TB+1)'(term);

  always_ff @(posedge clk) begin
    if (rst) v13 <= 1'b0;
    else if (adv) v13 <= v12;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      off13 <= sat_time(WIDE'(tot));
      lin13 <= lin12;
    end
  end

  // stage 14: clamp to the span, place, mirror
  logic [31:0] offc, mapped;
  logic        v14;
  logic [31:0] m14;

  assign offc = lin_path ? lin13 :
                ((MW'(off13) > MW'(room)) ? room : 32'(off13));
  assign mapped = empty_span ? source_in :
                  reverse    ? (source_out - 32'd1 - offc) : (source_in + offc);

  always_ff @(posedge clk) begin
    if (rst) v14 <= 1'b0;
    else if (adv) v14 <= v13;
  end
  always_ff @(posedge clk) begin
    if (adv) m14 <= mapped;
  end

  // ---------------------------------------------------------------------------
  // output register with skid stage
  logic        push, out_free;
  logic [31:0] skid_data;

  assign push     = v14 && adv;
  assign out_free = !source_valid || !source_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (out_free) begin
      if (skid_full) begin
        source_valid <= 1'b1;
        skid_full    <= 1'b0;
      end else begin
        source_valid <= push;
      end
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_full) source_position <= skid_data;
      else if (push) source_position <= m14;
    end
    if (push && !out_free) skid_data <= m14;
  end

`ifndef NO_ASSERTIONS
  // skid only ever holds a beat behind a waiting output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> source_valid)
    else $error("skid register full with no output beat");

  // skid fills only when the output beat was held
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(source_valid && source_stall))
    else $error("skid filled while output was free");

  // a frozen pipeline keeps its last stage
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(v14) && $stable(m14)))
    else $error("last stage changed while frozen");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/speed_profile_frame_mapper_tb.sv -----
// Self-checking testbench for the speed-profile frame mapper.
// Predicts each source position from the register settings and compares it
// with every result beat. Depends on spfm_pkg and speed_profile_frame_mapper.
`timescale 1ns / 1ps

module speed_profile_frame_mapper_tb;

  localparam int FRAC = 16;
  localparam longint unsigned ONE_Q = 64'd1 << FRAC;
  localparam longint unsigned SPEED_MAX = (64'd1 << (8 + FRAC)) - 1;
  localparam longint unsigned TIME_MAX = (64'd1 << 32) - 1;
  localparam int LATENCY = 60;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_TRIGGER = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic local_valid = 1'b0;
  logic local_stall;
  logic signed [31:0] local_position = '0;
  logic source_valid;
  logic source_stall = 1'b0;
  logic [31:0] source_position;

  speed_profile_frame_mapper dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .local_valid(local_valid), .local_stall(local_stall),
    .local_position(local_position), .source_valid(source_valid),
    .source_stall(source_stall), .source_position(source_position)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers
  longint unsigned clip_dur, src_in, src_out, base_speed, rev_en, prof, strength;

  logic [31:0] pending_pos[$];
  logic [31:0] expected_pos[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit pattern_stall = 1'b0;

  function automatic longint unsigned qc(longint unsigned n, longint unsigned d);
    return (ONE_Q * n + d / 2) / d;
  endfunction

  function automatic longint unsigned speed_mul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    p = (a * b) >> FRAC;
    return p > SPEED_MAX ? SPEED_MAX : p;
  endfunction

  function automatic longint unsigned speed_floor(longint unsigned x);
    if (x > SPEED_MAX) x = SPEED_MAX;
    return x < qc(1, 10) ? qc(1, 10) : x;
  endfunction

  function automatic longint unsigned time_add(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > TIME_MAX) ? TIME_MAX : s;
  endfunction

  function automatic longint unsigned ramp(longint unsigned b, longint unsigned st,
                                           longint unsigned k);
    longint unsigned f, m;
    if (st >= ONE_Q) begin
      f = ONE_Q + (((st - ONE_Q) * k) >> FRAC);
    end else begin
      m = ((ONE_Q - st) * k) >> FRAC;
      if (m >= ONE_Q) return qc(1, 10);
      f = ONE_Q - m;
    end
    return speed_floor(speed_mul(b, f));
  endfunction

  function automatic longint unsigned slowed(longint unsigned b, longint unsigned st);
    longint unsigned q;
    q = (qc(11, 20) << FRAC) / st;
    if (q < qc(9, 50)) q = qc(9, 50);
    if (q > qc(9, 10)) q = qc(9, 10);
    return speed_floor(speed_mul(b, q));
  endfunction

  function automatic longint unsigned lmax(longint unsigned a, longint unsigned b);
    return a > b ? a : b;
  endfunction

  // trapezoid integral of the speed curve up to pos
  function automatic longint unsigned curve_offset(longint unsigned t[3], longint unsigned s[3],
                                                   int n, longint unsigned pos);
    longint unsigned acc, span, dt, cs;
    acc = 0;
    if (pos == 0) return 0;
    for (int k = 1; k < n; k++) begin
      span = t[k] - t[k-1];
      if (pos <= t[k]) begin
        dt = pos - t[k-1];
        if (s[k] >= s[k-1]) cs = s[k-1] + ((s[k] - s[k-1]) * dt) / (2 * span);
        else cs = s[k-1] - ((s[k-1] - s[k]) * dt) / (2 * span);
        return time_add(acc, (dt * cs) >> FRAC);
      end
      acc = time_add(acc, (span * ((s[k] + s[k-1]) >> 1)) >> FRAC);
    end
    return acc;
  endfunction

  function automatic logic [31:0] map_position(logic [31:0] raw);
    longint unsigned dur, pos, b, st, mapped, off, room, e_u, m_u;
    longint unsigned t[3], s[3], sp0, spm, spe;
    int n;
    bit three;
    dur = clip_dur < 1 ? 1 : clip_dur;
    if (src_out <= src_in) return src_in[31:0];
    if (raw[31]) pos = 0;
    else pos = (raw > dur - 1) ? dur - 1 : raw;
    b = base_speed < qc(1, 10) ? qc(1, 10) : base_speed;
    st = strength;
    if (st < qc(1, 10)) st = qc(1, 10);
    if (st > 4 * ONE_Q) st = 4 * ONE_Q;
    room = src_out - 1 - src_in;
    if (prof == spfm_pkg::PROF_LINEAR || dur == 1) begin
      off = (pos * b + ONE_Q / 2) >> FRAC;
      mapped = src_in + (off > room ? room : off);
    end else begin
      sp0 = b; spm = b; spe = b;
      e_u = dur - 1; m_u = e_u / 2; n = 0;
      three = (prof == spfm_pkg::PROF_EASE_IN_OUT || prof == spfm_pkg::PROF_HYPERLAPSE);
      if (prof == spfm_pkg::PROF_EASE_IN) begin
        sp0 = slowed(b, st); spe = ramp(b, st, qc(17, 20));
      end else if (prof == spfm_pkg::PROF_EASE_OUT) begin
        sp0 = ramp(b, st, qc(17, 20)); spe = slowed(b, st);
      end else if (prof == spfm_pkg::PROF_EASE_IN_OUT) begin
        sp0 = slowed(b, st); spm = ramp(b, st, qc(23, 20)); spe = sp0;
      end else if (prof == spfm_pkg::PROF_HYPERLAPSE) begin
        sp0 = speed_floor(lmax(b, ONE_Q));
        spm = speed_floor(lmax(speed_mul(b, qc(29, 20)), speed_mul(st, qc(6, 5))));
        spe = speed_floor(lmax(speed_mul(b, 2 * ONE_Q), speed_mul(st, qc(9, 5))));
      end
      // middle point at time zero replaces the start point
      if (three && m_u == 0) begin
        t[n] = 0; s[n] = spm; n++;
      end else begin
        t[n] = 0; s[n] = sp0; n++;
        if (three) begin
          t[n] = m_u; s[n] = spm; n++;
        end
      end
      t[n] = e_u; s[n] = spe; n++;
      off = curve_offset(t, s, n, pos);
      if (off > room) off = room;
      mapped = src_in + off;
    end
    if (rev_en != 0) mapped = src_out - 1 - (mapped - src_in);
    return mapped[31:0];
  endfunction

  // APB write: setup then access cycle
  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      spfm_pkg::REG_CLIP_DURATION:  clip_dur = val;
      spfm_pkg::REG_SOURCE_IN:      src_in = val;
      spfm_pkg::REG_SOURCE_OUT:     src_out = val;
      spfm_pkg::REG_PLAYBACK_SPEED: base_speed = val[23:0];
      spfm_pkg::REG_REVERSE:        rev_en = val[0];
      spfm_pkg::REG_PROFILE:        prof = val[2:0];
      spfm_pkg::REG_CURVE_STRENGTH: strength = val[23:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] d, logic [31:0] si, logic [31:0] so,
                           logic [23:0] sp, logic r, logic [2:0] p, logic [23:0] st);
    reg_write(spfm_pkg::REG_CLIP_DURATION, d);
    reg_write(spfm_pkg::REG_SOURCE_IN, si);
    reg_write(spfm_pkg::REG_SOURCE_OUT, so);
    reg_write(spfm_pkg::REG_PLAYBACK_SPEED, {8'd0, sp});
    reg_write(spfm_pkg::REG_REVERSE, {31'd0, r});
    reg_write(spfm_pkg::REG_PROFILE, {29'd0, p});
    reg_write(spfm_pkg::REG_CURVE_STRENGTH, {8'd0, st});
  endtask

  // append one position to the driver queue
  task automatic queue_pos(logic [31:0] pos);
    pending_pos = {pending_pos, pos};
  endtask

  // wait until all beats are through and the pipe has drained
  task automatic drain();
    while (pending_pos.size() != 0 || expected_pos.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_position(longint unsigned d);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom;
      2: return 32'(d - 1);
      3: return 32'(d);
      default: return $urandom_range(0, (d > 1) ? 32'(d - 1) : 32'd0);
    endcase
  endfunction

  // driver: bursts of random length with gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      local_valid <= 1'b0;
    end else begin
      if (local_valid && !local_stall) begin
        expected_pos = {expected_pos, map_position(local_position)};
        void'(pending_pos.pop_front());
      end
      if (local_valid && local_stall) begin
        // hold payload
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        local_valid <= 1'b0;
      end else if (pending_pos.size() > 0) begin
        local_valid <= 1'b1;
        local_position <= pending_pos[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        local_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, overridden by one long hold-off once the queue backs up
  always @(posedge clk) begin
    if (rst) begin
      pattern_stall <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      pattern_stall <= ($urandom_range(0, 2) == 0);
    end
  end
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && pending_pos.size() >= HOLD_TRIGGER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end
  always @(posedge clk) source_stall <= (hold_left > 0) | pattern_stall;

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (source_valid && !source_stall) begin
        if (expected_pos.size() == 0) begin
          $error("source_position: no beat expected, actual %0d", source_position);
          errors++;
        end else if (expected_pos[0] !== source_position) begin
          $error("source_position: expected %0d actual %0d", expected_pos[0],
                 source_position);
          errors++;
          void'(expected_pos.pop_front());
        end else begin
          void'(expected_pos.pop_front());
        end
      end
      if ((source_valid && !source_stall) || (local_valid && !local_stall) || psel ||
          (hold_left > 0) || (pending_pos.size() == 0 && expected_pos.size() == 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stimulus
  logic [31:0] d_pick;
  initial begin
    clip_dur = 1; src_in = 0; src_out = 1; base_speed = 65536;
    rev_en = 0; prof = 0; strength = 65536;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes and every profile
    for (int p = 0; p < 8; p++) begin
      configure(100, 1000, 5000, 24'h010000, p[0], p[2:0], 24'h018000);
      queue_pos(32'd0);
      queue_pos(32'd99);
      queue_pos(32'h7FFF_FFFF);
      drain();
    end
    // empty span, single-unit clip, middle point at zero
    configure(10, 500, 500, 24'h010000, 0, spfm_pkg::PROF_EASE_IN, 24'h010000);
    queue_pos(32'd5);
    drain();
    configure(1, 0, 32'hFFFF_FFFF, 24'hFFFFFF, 1, spfm_pkg::PROF_HYPERLAPSE, 24'hFFFFFF);
    queue_pos(32'h8000_0000);
    queue_pos(32'd3);
    drain();
    configure(2, 0, 32'hFFFF_FFFF, 24'h000000, 0, spfm_pkg::PROF_EASE_IN_OUT, 24'h000000);
    queue_pos(32'd1);
    queue_pos(32'hFFFF_FFFF);
    drain();
    configure(0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 24'h000001, 0, spfm_pkg::PROF_HYPERLAPSE,
              24'h000001);
    queue_pos(32'd0);
    drain();
    // random phases
    for (int ph = 0; ph < 20; ph++) begin
      case ($urandom_range(0, 3))
        0: d_pick = $urandom_range(1, 8);
        1: d_pick = $urandom;
        default: d_pick = $urandom_range(2, 5000);
      endcase
      configure(d_pick, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1000),
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1000, 2000000),
                24'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 24'h40000)),
                1'($urandom), 3'($urandom_range(0, 7)),
                24'(($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 24'h50000)));
      if (ph == 10) begin
        // large batch so the receiver hold-off fills the block
        for (int i = 0; i < 150; i++) queue_pos(rand_position(clip_dur));
      end else begin
        for (int i = 0; i < 45; i++) queue_pos(rand_position(clip_dur));
      end
      drain();
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
